@@ design/battery_charge_monitor_core_assert.svh @@
// assertion macros shared by the checker
`ifndef BATTERY_CHARGE_MONITOR_CORE_ASSERT_SVH
`define BATTERY_CHARGE_MONITOR_CORE_ASSERT_SVH
`define BCM_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define BCM_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

@@ design/bcm_pkg.sv @@
package bcm_pkg;
	localparam int unsigned MV_W = 15;
	localparam logic [15:0] MV_MAX = 16'd32767;
	localparam logic [15:0] JUMP_MV = 16'd5000;
	localparam logic [9:0] ADC_MID = 10'd511;
	localparam logic [22:0] CUR_NUM = 23'd5000000;
	localparam logic [9:0] ADC_FULL = 10'd1023;
	localparam logic [14:0] CUR_MIN_MA = 15'd40;
	localparam logic [15:0] CHG_MIN_MV = 16'd5000;
	localparam int unsigned NUM_W = 32;
	localparam int unsigned DEN_W = 20;

	localparam int unsigned REG_BAT_SCALE = 0;
	localparam int unsigned REG_CHG_SCALE = 1;
	localparam int unsigned REG_SENS = 2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // latch input item, start
		logic chan_bat;  // battery channel update step
		logic chan_chg;  // charge channel update step
		logic div_step;  // one restoring division step
		logic avg_load;  // load averaging division
		logic avg_sel;   // 0 battery, 1 charge
		logic avg_done;  // write average quotient
		logic cur_load;  // load current division
		logic finish;    // current result and capacity update
	} bcm_cmd_t;

	typedef struct packed {
		logic bat_jump;
		logic chg_jump;
	} bcm_sts_t;
endpackage

@@ design/bcm_ram.sv @@
module bcm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ design/bcm_ctrl.sv @@
module bcm_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_fire,
	input  bcm_pkg::bcm_sts_t sts,
	output logic busy,
	output logic out_valid,
	output bcm_pkg::bcm_cmd_t cmd
);
	localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_BAT = 4'd2, S_CHG = 4'd3,
		S_AVG_B = 4'd4, S_DIV_B = 4'd5, S_AVG_C = 4'd6, S_DIV_C = 4'd7,
		S_CUR = 4'd8, S_DIV_I = 4'd9, S_FIN = 4'd10, S_OUT = 4'd11;

	logic [3:0] state_q;
	logic [5:0] cnt_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 6'd1;
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_READ;
				S_READ: state_q <= S_BAT;
				S_BAT: state_q <= S_CHG;
				S_CHG: state_q <= sts.bat_jump ? (sts.chg_jump ? S_CUR : S_AVG_C) : S_AVG_B;
				S_AVG_B: begin state_q <= S_DIV_B; cnt_q <= '0; end
				S_DIV_B: if (cnt_q == 6'd22) state_q <= sts.chg_jump ? S_CUR : S_AVG_C;
				S_AVG_C: begin state_q <= S_DIV_C; cnt_q <= '0; end
				S_DIV_C: if (cnt_q == 6'd22) state_q <= S_CUR;
				S_CUR: begin state_q <= S_DIV_I; cnt_q <= '0; end
				S_DIV_I: if (cnt_q == 6'd31) state_q <= S_FIN;
				S_FIN: state_q <= S_OUT;
				S_OUT: if (out_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		cmd.chan_bat = (state_q == S_BAT);
		cmd.chan_chg = (state_q == S_CHG);
		cmd.avg_load = (state_q == S_AVG_B) || (state_q == S_AVG_C);
		cmd.avg_sel = (state_q == S_AVG_C) || (state_q == S_DIV_C);
		cmd.div_step = (state_q == S_DIV_B) || (state_q == S_DIV_C) || (state_q == S_DIV_I);
		cmd.avg_done = ((state_q == S_DIV_B) || (state_q == S_DIV_C)) && (cnt_q == 6'd22);
		cmd.cur_load = (state_q == S_CUR);
		cmd.finish = (state_q == S_FIN);
	end

	assign busy = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
endmodule

@@ design/bcm_dp.sv @@
module bcm_dp #(
	parameter int WINDOW_LEN = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  bcm_pkg::bcm_cmd_t cmd,
	output bcm_pkg::bcm_sts_t sts,
	input  logic [29:0] in_data,
	input  logic [15:0] bat_scale,
	input  logic [15:0] chg_scale,
	input  logic [9:0] sens,
	output logic [14:0] battery_mv,
	output logic [14:0] charge_mv,
	output logic [14:0] charge_ma,
	output logic [31:0] capacity_mas
);
	localparam int AW = $clog2(WINDOW_LEN > 1 ? WINDOW_LEN : 2);
	localparam int FW = $clog2(WINDOW_LEN + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_LEN - 1);
	localparam logic [FW-1:0] FULL = FW'(WINDOW_LEN);

	logic [9:0] bs_q, cs_q, is_q;
	logic [15:0] bmv_q, cmv_q;
	logic [15:0] blev_q, clev_q;
	logic [21:0] bsum_q, csum_q;
	logic [FW-1:0] bfill_q, cfill_q;
	logic [AW-1:0] bslot_q, cslot_q;
	logic [31:0] cap_q;
	logic [14:0] ima_q;
	logic [15:0] bold, cold;
	logic [31:0] num_q, rem_q;
	logic [19:0] den_q;
	logic bj, cj;
	logic bjump_q, cjump_q;

	// window memories, read at current slot
	bcm_ram #(.WIDTH(16), .DEPTH(WINDOW_LEN)) u_bwin (.clk(clk),
		.we(cmd.chan_bat && !bj), .waddr(bslot_q), .wdata(bmv_q),
		.raddr(bslot_q), .rdata(bold));
	bcm_ram #(.WIDTH(16), .DEPTH(WINDOW_LEN)) u_cwin (.clk(clk),
		.we(cmd.chan_chg && !cj), .waddr(cslot_q), .wdata(cmv_q),
		.raddr(cslot_q), .rdata(cold));

	// scaling, one multiply per channel
	function automatic logic [15:0] scale_mv(input logic [9:0] s, input logic [15:0] k);
		logic [25:0] p;
		p = s * k;
		return (p[25:8] > 18'(bcm_pkg::MV_MAX)) ? bcm_pkg::MV_MAX : p[23:8];
	endfunction

	function automatic logic jump(input logic [15:0] lev, input logic [15:0] mv);
		logic [15:0] d;
		d = (lev > mv) ? lev - mv : mv - lev;
		return d > bcm_pkg::JUMP_MV;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bs_q <= in_data[9:0];
			cs_q <= in_data[19:10];
			is_q <= in_data[29:20];
		end else begin
			bmv_q <= scale_mv(bs_q, bat_scale);
			cmv_q <= scale_mv(cs_q, chg_scale);
		end
	end

	// jump decisions taken against the levels before this item
	assign bj = jump(blev_q, bmv_q);
	assign cj = jump(clev_q, cmv_q);
	assign sts.bat_jump = bjump_q;
	assign sts.chg_jump = cjump_q;

	// channel state, running sums and the shared divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blev_q <= '0; clev_q <= '0; bsum_q <= '0; csum_q <= '0;
			bfill_q <= '0; cfill_q <= '0; bslot_q <= '0; cslot_q <= '0;
			cap_q <= '0; ima_q <= '0;
			num_q <= '0; rem_q <= '0; den_q <= '0;
			bjump_q <= 1'b0; cjump_q <= 1'b0;
		end else begin
			if (cmd.chan_bat) begin
				bjump_q <= bj;
				cjump_q <= cj;
				if (bj) blev_q <= bmv_q;
				else begin
					bsum_q <= bsum_q + 22'(bmv_q) - ((bfill_q >= FULL) ? 22'(bold) : 22'd0);
					if (bfill_q < FULL) bfill_q <= bfill_q + FW'(1);
					bslot_q <= (bslot_q == LAST_SLOT) ? '0 : bslot_q + AW'(1);
				end
			end
			if (cmd.chan_chg) begin
				if (cj) clev_q <= cmv_q;
				else begin
					csum_q <= csum_q + 22'(cmv_q) - ((cfill_q >= FULL) ? 22'(cold) : 22'd0);
					if (cfill_q < FULL) cfill_q <= cfill_q + FW'(1);
					cslot_q <= (cslot_q == LAST_SLOT) ? '0 : cslot_q + AW'(1);
				end
			end
			if (cmd.avg_load) begin
				num_q <= {cmd.avg_sel ? csum_q : bsum_q, 10'd0};
				rem_q <= '0;
				den_q <= 20'(cmd.avg_sel ? cfill_q : bfill_q);
			end else if (cmd.cur_load) begin
				num_q <= (is_q > bcm_pkg::ADC_MID)
					? (32'(is_q - bcm_pkg::ADC_MID) * 32'(bcm_pkg::CUR_NUM)) : 32'd0;
				rem_q <= '0;
				den_q <= 20'(bcm_pkg::ADC_FULL) * 20'((sens == 10'd0) ? 10'd1 : sens);
			end else if (cmd.div_step) begin
				logic [32:0] tr;
				tr = {rem_q, num_q[31]} - {13'd0, den_q};
				if (!tr[32]) begin
					rem_q <= tr[31:0];
					num_q <= {num_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], num_q[31]};
					num_q <= {num_q[30:0], 1'b0};
				end
			end
			// average quotient ends after 22 steps (sum in top 22 bits)
			if (cmd.avg_done) begin
				if (cmd.avg_sel) clev_q <= num_q[15:0];
				else blev_q <= num_q[15:0];
			end
			// current clamp and capacity, divide by ten via reciprocal multiply
			if (cmd.finish) begin
				logic [14:0] i;
				logic [31:0] inc;
				logic [31:0] prod;
				i = (num_q > 32'(bcm_pkg::MV_MAX)) ? 15'(bcm_pkg::MV_MAX) : num_q[14:0];
				ima_q <= i;
				prod = (32'(i) + 32'd5) * 32'd52429;
				inc = 32'(prod[31:19]);
				if (i > bcm_pkg::CUR_MIN_MA && clev_q > bcm_pkg::CHG_MIN_MV)
					cap_q <= (cap_q > ~inc) ? 32'hFFFF_FFFF : cap_q + inc;
			end
		end
	end

	assign battery_mv = blev_q[14:0];
	assign charge_mv = clev_q[14:0];
	assign charge_ma = ima_q;
	assign capacity_mas = cap_q;
endmodule

@@ design/battery_charge_monitor_core.sv @@
// Battery charge monitor: takes one transfer of three 10-bit ADC samples and returns
// filtered battery and charge voltages, charge current and the capacity counter.
// One item at a time: s_tready is low from the accepting edge until the result transfer.
// m_tvalid rises sooner after the input transfer when both voltages jump than when both
// are averaged, set by the shared restoring divider (each voltage average and then the
// current, one quotient bit a cycle); the controller returns to idle after each result
// transfer, and the core takes no new item while it is busy or the output stalls.
// Windows are small RAMs guarded by fill counts; no clearing pass is needed.
module battery_charge_monitor_core #(
	parameter int WINDOW_LEN = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata,  // battery_sample, charge_sample, current_sample, pad
	output logic m_tvalid,
	input  logic m_tready,
	output logic [79:0] m_tdata,  // battery_mv, charge_mv, charge_ma, capacity_mas, pad
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	logic [15:0] bat_scale_q, chg_scale_q;
	logic [9:0] sens_q;
	logic busy;
	bcm_pkg::bcm_cmd_t cmd;
	bcm_pkg::bcm_sts_t sts;
	logic [14:0] bmv, cmv, ima;
	logic [31:0] cap;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bat_scale_q <= 16'd12800;
			chg_scale_q <= 16'd12800;
			sens_q <= 10'd185;
		end else if (cfg_we) begin
			case (32'(cfg_index))
				bcm_pkg::REG_BAT_SCALE: bat_scale_q <= cfg_data;
				bcm_pkg::REG_CHG_SCALE: chg_scale_q <= cfg_data;
				bcm_pkg::REG_SENS: sens_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !busy;

	bcm_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready),
		.out_fire(m_tvalid && m_tready), .sts(sts), .busy(busy),
		.out_valid(m_tvalid), .cmd(cmd));

	bcm_dp #(.WINDOW_LEN(WINDOW_LEN)) u_dp (.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.sts(sts), .in_data(s_tdata[29:0]), .bat_scale(bat_scale_q),
		.chg_scale(chg_scale_q), .sens(sens_q), .battery_mv(bmv), .charge_mv(cmv),
		.charge_ma(ima), .capacity_mas(cap));

	assign m_tdata = {3'd0, cap, ima, cmv, bmv};
endmodule

@@ design/bcm_checker.sv @@
`include "battery_charge_monitor_core_assert.svh"
module bcm_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [79:0] m_tdata
);
	// no new transfer accepted while a result waits
	`BCM_ASSERT_IMPL(a_no_accept_out, clk, arst_n, m_tvalid, !s_tready)
	// a result holds while stalled
	`BCM_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// an accepted item does not produce a result next cycle
	`BCM_ASSERT_NEXT(a_latency, clk, arst_n, s_tvalid && s_tready, !m_tvalid)
endmodule

bind battery_charge_monitor_core bcm_checker u_chk (.clk(clk), .arst_n(arst_n),
	.s_tvalid(s_tvalid), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata));

@@ bench/tb_battery_charge_monitor_core.sv @@
`timescale 1ns / 1ps

class charge_scoreboard;
	// configuration copy
	bit [15:0] bat_scale;
	bit [15:0] chg_scale;
	bit [9:0]  sens;
	// per channel running-average state, index 0 battery, 1 charge
	bit [15:0] win [2][8];
	bit [18:0] sum [2];
	bit [3:0]  fill [2];
	bit [2:0]  slot [2];
	bit [15:0] level [2];
	bit [31:0] capacity;
	bit [79:0] pending [$];
	int        errors;

	function void clear();
		bat_scale = 16'd12800;
		chg_scale = 16'd12800;
		sens = 10'd185;
		for (int c = 0; c < 2; c++) begin
			sum[c] = 0;
			fill[c] = 0;
			slot[c] = 0;
			level[c] = 0;
		end
		capacity = 0;
		pending.delete();
		errors = 0;
	endfunction

	function void set_reg(int idx, bit [15:0] val);
		case (idx)
			bcm_pkg::REG_BAT_SCALE: bat_scale = val;
			bcm_pkg::REG_CHG_SCALE: chg_scale = val;
			bcm_pkg::REG_SENS: sens = val[9:0];
			default: ;
		endcase
	endfunction

	function bit [15:0] to_mv(bit [9:0] s, bit [15:0] k);
		bit [25:0] p;
		p = (s * k) >> 8;
		return (p > 26'd32767) ? 16'd32767 : p[15:0];
	endfunction

	function void filter(int c, bit [15:0] mv);
		int diff;
		diff = int'(level[c]) - int'(mv);
		if (diff < 0)
			diff = -diff;
		if (diff > 5000) begin
			level[c] = mv;
			return;
		end
		if (fill[c] >= 8)
			sum[c] -= win[c][slot[c]];
		else
			fill[c]++;
		win[c][slot[c]] = mv;
		sum[c] += mv;
		slot[c]++;
		level[c] = 16'(sum[c] / fill[c]);
	endfunction

	// note an accepted sample set and queue the expected reading
	function void note_input(bit [31:0] d);
		longint d_adc, q, den;
		bit [31:0] ma, inc;
		filter(0, to_mv(d[9:0], bat_scale));
		filter(1, to_mv(d[19:10], chg_scale));
		d_adc = longint'(d[29:20]) - 511;
		ma = 0;
		if (d_adc > 0) begin
			den = 1023 * ((sens == 0) ? 1 : sens);
			q = (d_adc * 5000000) / den;
			ma = (q > 32767) ? 32'd32767 : 32'(q);
		end
		if (ma > 40 && level[1] > 5000) begin
			inc = (ma + 5) / 10;
			capacity = (capacity > 32'hFFFFFFFF - inc) ? 32'hFFFFFFFF : capacity + inc;
		end
		pending.push_back({3'b000, capacity, ma[14:0], level[1][14:0], level[0][14:0]});
	endfunction

	// compare one reading with the oldest expectation
	function void check_output(bit [79:0] got);
		bit [79:0] exp;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected reading %h", got);
			return;
		end
		exp = pending.pop_front();
		if (exp[14:0] !== got[14:0] || exp[29:15] !== got[29:15]
				|| exp[44:30] !== got[44:30] || exp[76:45] !== got[76:45]) begin
			errors++;
			if (errors <= 10)
				$display("mismatch bat %0d/%0d chg %0d/%0d ma %0d/%0d cap %0d/%0d",
					exp[14:0], got[14:0], exp[29:15], got[29:15],
					exp[44:30], got[44:30], exp[76:45], got[76:45]);
		end
	endfunction
endclass

module tb_battery_charge_monitor_core;
	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // battery_sample, charge_sample, current_sample, pad
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;   // battery_mv, charge_mv, charge_ma, capacity_mas, pad
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	charge_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off;

	battery_charge_monitor_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#40ms;
		$display("Regression FAIL");
		$finish;
	end

	// receiver with random stalls and a long hold-off
	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready <= 0;
				hold_off--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_output(m_tdata);
	end

	task automatic write_reg(int idx, bit [15:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= 2'(idx);
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	// one transfer; returns after valid drops
	task automatic send_item(bit [9:0] b, bit [9:0] c, bit [9:0] i);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		s_tvalid <= 1;
		s_tdata <= {2'b00, i, c, b};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input({2'b00, i, c, b});
		@(negedge clk);
		s_tvalid <= 0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	// random sample set, mostly near a steady level with occasional jumps
	task automatic send_random(bit [9:0] bat_base, bit [9:0] chg_base);
		bit [9:0] b, c;
		b = ($urandom_range(9) == 0) ? 10'($urandom_range(1023))
			: 10'(bat_base + $urandom_range(20) - 10);
		c = ($urandom_range(9) == 0) ? 10'($urandom_range(1023))
			: 10'(chg_base + $urandom_range(20) - 10);
		send_item(b, c, 10'($urandom_range(1023)));
	endtask

	initial begin
		bit [9:0] bb, cb;
		sb = new();
		sb.clear();
		s_tvalid = 0;
		s_tdata = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, jumps, window wrap, current edges
		send_item(0, 0, 0);
		send_item(1023, 1023, 1023);
		send_item(0, 0, 511);
		send_item(10'h155, 10'h2AA, 512);
		for (int k = 0; k < 10; k++)
			send_item(10'(100 + k), 10'(200 + k), 10'(600 + 40 * k));
		send_item(1023, 1023, 10'h3FF);
		drain();
		write_reg(bcm_pkg::REG_SENS, 0);
		write_reg(bcm_pkg::REG_BAT_SCALE, 16'hFFFF);
		write_reg(bcm_pkg::REG_CHG_SCALE, 16'hFFFF);
		send_item(1023, 1023, 1023);
		send_item(1, 1, 513);
		send_item(1023, 1023, 520);
		drain();
		write_reg(bcm_pkg::REG_SENS, 1000);
		write_reg(bcm_pkg::REG_BAT_SCALE, 0);
		write_reg(bcm_pkg::REG_CHG_SCALE, 0);
		send_item(1023, 1023, 1023);
		send_item(512, 512, 600);
		drain();

		// random phases with different settings and idling
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			write_reg(bcm_pkg::REG_BAT_SCALE,
				(ph == 7) ? 16'hFFFF : 16'($urandom_range(65535)));
			write_reg(bcm_pkg::REG_CHG_SCALE,
				(ph == 7) ? 16'hFFFF : 16'(12800 + $urandom_range(8000)));
			write_reg(bcm_pkg::REG_SENS, (ph == 6) ? 16'd1 : 16'($urandom_range(1000)));
			bb = 10'($urandom_range(1023));
			cb = 10'(200 + $urandom_range(800));
			if (ph == 2)
				hold_off = 2000;
			for (int k = 0; k < 140; k++) begin
				if (k % 40 == 39) begin
					bb = 10'($urandom_range(1023));
					cb = 10'($urandom_range(1023));
				end
				send_random(bb, cb);
			end
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
